// ===== rtl/eihp_pkg.sv =====
// ----------------------------------------------------------------------------
// eihp_pkg
// Shared types and constants for the Ethernet/IPv4/TCP header parser.
// ----------------------------------------------------------------------------
package eihp_pkg;

  // Bytes of Ethernet header skipped before the IPv4 header starts.
  localparam logic [15:0] EthHdrBytes = 16'd14;

  // Smallest legal IPv4 and TCP header length in bytes.
  localparam logic [5:0] MinHdrBytes = 6'd20;

  // IPv4 header byte offsets of the fields that are captured.
  localparam logic [15:0] OffIhl      = 16'd0;
  localparam logic [15:0] OffLenHi    = 16'd2;
  localparam logic [15:0] OffLenLo    = 16'd3;
  localparam logic [15:0] OffProto    = 16'd9;
  localparam logic [15:0] OffSrcFirst = 16'd12;
  localparam logic [15:0] OffSrcLast  = 16'd15;
  localparam logic [15:0] OffDstFirst = 16'd16;
  localparam logic [15:0] OffDstLast  = 16'd19;

  // TCP header byte offsets.
  localparam logic [15:0] OffPortsLast = 16'd3;
  localparam logic [15:0] OffDataOfs   = 16'd12;

  localparam logic [7:0] ProtoZero = 8'd0;
  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp  = 8'd6;

  typedef enum logic [0:0] {
    KindSummary = 1'b0,
    KindData    = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    StTcpOk     = 3'd0,
    StIpProto0  = 3'd1,
    StIcmp      = 3'd2,
    StOther     = 3'd3,
    StBadIpLen  = 3'd4,
    StBadTcpLen = 3'd5,
    StTruncated = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    PhStart   = 4'b0001,
    PhHeader  = 4'b0010,
    PhPayload = 4'b0100,
    PhDone    = 4'b1000
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [31:0] packet_number;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [7:0]  protocol_number;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
    logic        data_last;
  } result_t;

endpackage

// ===== rtl/eihp_in_stage.sv =====
// ----------------------------------------------------------------------------
// eihp_in_stage
// Input register: holds one frame byte until the parser takes it.
// ----------------------------------------------------------------------------
module eihp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  input  logic       end_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o,
  output logic       end_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       end_q;
  logic       accept;

  assign ready_o = !valid_q || take_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= byte_i;
      end_q  <= end_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign end_o   = end_q;

endmodule

// ===== rtl/eihp_parse.sv =====
// ----------------------------------------------------------------------------
// eihp_parse
// Parser state and the single-pass step logic for one frame byte.
// ----------------------------------------------------------------------------
module eihp_parse #(
  parameter logic [15:0] EthHdrBytes = eihp_pkg::EthHdrBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              end_i,
  output logic              res_valid_o,
  output eihp_pkg::result_t res_o
);

  eihp_pkg::phase_e  phase_q, phase_d;
  logic [15:0]       pos_q, pos_d;
  logic [5:0]        ihl_q, ihl_d;
  logic [5:0]        thl_q, thl_d;
  logic [15:0]       tot_q, tot_d;
  logic [7:0]        proto_q, proto_d;
  logic [31:0]       src_q, src_d;
  logic [31:0]       dst_q, dst_d;
  logic [31:0]       ports_q, ports_d;
  logic [15:0]       rem_q, rem_d;
  logic [31:0]       count_q, count_d;

  logic              start;
  logic [15:0]       pos;
  logic [15:0]       q;
  logic [15:0]       t;
  logic [6:0]        hdr;
  logic [15:0]       plen;
  logic              emit_sum;
  logic              emit_data;
  logic              last;
  eihp_pkg::status_e sum_st;

  always_comb begin
    start   = (phase_q == eihp_pkg::PhStart);
    phase_d = start ? eihp_pkg::PhHeader : phase_q;
    count_d = start ? count_q + 32'd1 : count_q;
    pos     = start ? '0 : pos_q;
    ihl_d   = start ? '0 : ihl_q;
    thl_d   = start ? '0 : thl_q;
    tot_d   = start ? '0 : tot_q;
    proto_d = start ? '0 : proto_q;
    src_d   = start ? '0 : src_q;
    dst_d   = start ? '0 : dst_q;
    ports_d = start ? '0 : ports_q;
    rem_d   = start ? '0 : rem_q;

    q         = pos - EthHdrBytes;
    t         = q - 16'(ihl_d);
    hdr       = '0;
    plen      = '0;
    emit_sum  = 1'b0;
    emit_data = 1'b0;
    last      = 1'b0;
    sum_st    = eihp_pkg::StTruncated;

    if (phase_d == eihp_pkg::PhHeader && pos >= EthHdrBytes) begin
      priority if (q == eihp_pkg::OffIhl) begin
        ihl_d = {byte_i[3:0], 2'b00};
        if (ihl_d < eihp_pkg::MinHdrBytes) begin
          emit_sum = 1'b1;
          sum_st   = eihp_pkg::StBadIpLen;
          phase_d  = eihp_pkg::PhDone;
        end
      end else if (q == eihp_pkg::OffLenHi || q == eihp_pkg::OffLenLo) begin
        tot_d = {tot_d[7:0], byte_i};
      end else if (q == eihp_pkg::OffProto) begin
        proto_d = byte_i;
      end else if (q >= eihp_pkg::OffSrcFirst && q <= eihp_pkg::OffSrcLast) begin
        src_d = {src_d[23:0], byte_i};
      end else if (q >= eihp_pkg::OffDstFirst && q <= eihp_pkg::OffDstLast) begin
        dst_d = {dst_d[23:0], byte_i};
        if (q == eihp_pkg::OffDstLast && proto_d != eihp_pkg::ProtoTcp) begin
          emit_sum = 1'b1;
          phase_d  = eihp_pkg::PhDone;
          priority if (proto_d == eihp_pkg::ProtoZero) begin
            sum_st = eihp_pkg::StIpProto0;
          end else if (proto_d == eihp_pkg::ProtoIcmp) begin
            sum_st = eihp_pkg::StIcmp;
          end else begin
            sum_st = eihp_pkg::StOther;
          end
        end
      end else begin
        // Bytes not captured by the IPv4 header.
      end

      // The TCP header starts after the IPv4 header and any IP options.
      if (phase_d == eihp_pkg::PhHeader && q >= 16'(eihp_pkg::MinHdrBytes)
          && q >= 16'(ihl_d)) begin
        if (t <= eihp_pkg::OffPortsLast) begin
          ports_d = {ports_d[23:0], byte_i};
        end else if (t == eihp_pkg::OffDataOfs) begin
          thl_d    = {byte_i[7:4], 2'b00};
          emit_sum = 1'b1;
          if (thl_d < eihp_pkg::MinHdrBytes) begin
            sum_st  = eihp_pkg::StBadTcpLen;
            phase_d = eihp_pkg::PhDone;
          end else begin
            hdr     = {1'b0, ihl_d} + {1'b0, thl_d};
            plen    = (tot_d > 16'(hdr)) ? tot_d - 16'(hdr) : '0;
            sum_st  = eihp_pkg::StTcpOk;
            rem_d   = plen;
            phase_d = (plen != '0) ? eihp_pkg::PhPayload : eihp_pkg::PhDone;
          end
        end
      end
    end else if (phase_d == eihp_pkg::PhPayload) begin
      if (pos >= EthHdrBytes + 16'(ihl_d) + 16'(thl_d)) begin
        rem_d     = rem_d - 16'd1;
        emit_data = 1'b1;
        last      = (rem_d == '0) || end_i;
        if (rem_d == '0) begin
          phase_d = eihp_pkg::PhDone;
        end
      end
    end

    if (end_i) begin
      if (phase_d == eihp_pkg::PhHeader && !emit_sum) begin
        emit_sum = 1'b1;
        sum_st   = eihp_pkg::StTruncated;
      end
      phase_d = eihp_pkg::PhStart;
    end

    pos_d = (pos != '1) ? pos + 16'd1 : pos;

    res_o = '0;
    res_o.packet_number = count_d;
    if (emit_data) begin
      res_o.kind      = eihp_pkg::KindData;
      res_o.data_byte = byte_i;
      res_o.data_last = last;
    end else begin
      res_o.kind   = eihp_pkg::KindSummary;
      res_o.status = sum_st;
      res_o.protocol_number = proto_d;
      if (pos >= EthHdrBytes + eihp_pkg::OffSrcLast) begin
        res_o.source_address = src_d;
      end
      if (pos >= EthHdrBytes + eihp_pkg::OffDstLast) begin
        res_o.destination_address = dst_d;
      end
      if (sum_st == eihp_pkg::StTcpOk) begin
        res_o.source_port      = ports_d[31:16];
        res_o.destination_port = ports_d[15:0];
        res_o.payload_length   = plen;
      end
    end
    res_valid_o = emit_sum || emit_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= eihp_pkg::PhStart;
      pos_q   <= '0;
      ihl_q   <= '0;
      thl_q   <= '0;
      tot_q   <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      ports_q <= '0;
      rem_q   <= '0;
      count_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      ihl_q   <= ihl_d;
      thl_q   <= thl_d;
      tot_q   <= tot_d;
      proto_q <= proto_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      ports_q <= ports_d;
      rem_q   <= rem_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== rtl/eihp_out_stage.sv =====
// ----------------------------------------------------------------------------
// eihp_out_stage
// Result register: holds one result request until the consumer takes it.
// ----------------------------------------------------------------------------
module eihp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              res_valid_i,
  input  eihp_pkg::result_t res_i,
  input  logic              ready_i,
  output logic              free_o,
  output logic              valid_o,
  output eihp_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  eihp_pkg::result_t res_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q && !ready_i;
    if (load_i) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== rtl/ethernet_ipv4_tcp_header_parser.sv =====
// ----------------------------------------------------------------------------
// ethernet_ipv4_tcp_header_parser
// Parses captured Ethernet frames byte by byte, emits one summary request per
// frame and forwards the TCP payload bytes.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                       Payload
//   frame    in         frame_valid_i / frame_ready_o   frame_byte_i, frame_end_i
//   result   out        result_valid_o / result_ready_i result_* fields
//
// One frame byte is accepted per cycle while frame_ready_o is high. The step
// logic between the input and result registers is combinational, so a request
// is loaded into the result register when its byte leaves the input register.
// Reset returns the parser to the start of a frame and clears the frame count.
// A stalled result register lets the input register take one more byte, then
// frame_ready_o stays low until result_ready_i is high again.
// ----------------------------------------------------------------------------
module ethernet_ipv4_tcp_header_parser #(
  parameter logic [15:0] EthHdrBytes = eihp_pkg::EthHdrBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        frame_valid_i,
  output logic        frame_ready_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        frame_end_i,

  output logic        result_valid_o,
  input  logic        result_ready_i,
  output logic        result_kind_o,
  output logic [2:0]  status_o,
  output logic [31:0] packet_number_o,
  output logic [31:0] source_address_o,
  output logic [31:0] destination_address_o,
  output logic [7:0]  protocol_number_o,
  output logic [15:0] source_port_o,
  output logic [15:0] destination_port_o,
  output logic [15:0] payload_length_o,
  output logic [7:0]  data_byte_o,
  output logic        data_last_o
);

  // The input register holds a byte that has not yet gone through the parser.
  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_end_q;

  // The byte advances whenever the result register can take what it produces.
  logic              out_free;
  logic              advance;

  logic              step_valid;
  eihp_pkg::result_t step_res;
  eihp_pkg::result_t res_q;

  assign advance = in_valid_q && out_free;

  eihp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (frame_valid_i),
    .ready_o (frame_ready_o),
    .byte_i  (frame_byte_i),
    .end_i   (frame_end_i),
    .take_i  (advance),
    .valid_o (in_valid_q),
    .byte_o  (in_byte_q),
    .end_o   (in_end_q)
  );

  // The parser state moves only when a byte advances into the result stage.
  eihp_parse #(
    .EthHdrBytes (EthHdrBytes)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .end_i       (in_end_q),
    .res_valid_o (step_valid),
    .res_o       (step_res)
  );

  eihp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_valid_i (step_valid),
    .res_i       (step_res),
    .ready_i     (result_ready_i),
    .free_o      (out_free),
    .valid_o     (result_valid_o),
    .res_o       (res_q)
  );

  assign result_kind_o         = res_q.kind;
  assign status_o              = res_q.status;
  assign packet_number_o       = res_q.packet_number;
  assign source_address_o      = res_q.source_address;
  assign destination_address_o = res_q.destination_address;
  assign protocol_number_o     = res_q.protocol_number;
  assign source_port_o         = res_q.source_port;
  assign destination_port_o    = res_q.destination_port;
  assign payload_length_o      = res_q.payload_length;
  assign data_byte_o           = res_q.data_byte;
  assign data_last_o           = res_q.data_last;

  // The input side only stalls when both registers are full and the result
  // consumer is holding off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !frame_ready_o |-> in_valid_q && result_valid_o && !result_ready_i)
    else $error("frame_ready_o low without a blocked result register");

  // A byte waiting in the input register is neither lost nor altered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q) && $stable(in_end_q))
    else $error("input register dropped or changed a pending byte");

  // A forwarded payload byte never carries summary fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_kind_o == eihp_pkg::KindData
    |-> status_o == eihp_pkg::StTcpOk && payload_length_o == 16'd0
        && source_address_o == 32'd0 && protocol_number_o == 8'd0)
    else $error("payload byte request carries summary fields");

endmodule
